### rtl/core/pal_pkg.sv
// pal_pkg: shared constants, command and status codes, cell operation type
// for the positional array list. No dependencies.
package pal_pkg;

    // list geometry and field widths
    localparam int CAPACITY = 8;
    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 3;
    localparam int POS_W    = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    // command codes
    localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_POS  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REM_HEAD = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REM_TAIL = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REM_POS  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SHOW     = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd3;

    // what a cell loads at the next edge
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_FROM_HEAD
    } t_cell_op;

endpackage

### rtl/core/pal_cell.sv
// pal_cell: one storage cell of the list chain. Holds one entry and takes
// a new value from the command, a neighbor or the head. Uses pal_pkg.
module pal_cell (
    input  logic                              i_clk,
    input  pal_pkg::t_cell_op                 i_op,
    input  logic signed [pal_pkg::VALUE_W-1:0] i_load,
    input  logic signed [pal_pkg::VALUE_W-1:0] i_prev,
    input  logic signed [pal_pkg::VALUE_W-1:0] i_next,
    input  logic signed [pal_pkg::VALUE_W-1:0] i_head,
    output logic signed [pal_pkg::VALUE_W-1:0] o_value
);

    logic signed [pal_pkg::VALUE_W-1:0] r_value;
    logic signed [pal_pkg::VALUE_W-1:0] n_value;

    // source select
    always_comb begin
        case (i_op)
            pal_pkg::CELL_LOAD:      n_value = i_load;
            pal_pkg::CELL_FROM_PREV: n_value = i_prev;
            pal_pkg::CELL_FROM_NEXT: n_value = i_next;
            pal_pkg::CELL_FROM_HEAD: n_value = i_head;
            default:                 n_value = r_value;
        endcase
    end

    // entry storage, no reset: only cells below the count are ever read
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

### rtl/core/positional_array_list.sv
// positional_array_list: bounded packed list built as a chain of cells.
// A command's result is registered in the cycle after its transfer; a show
// enters S_SHOW and then emits the entries in order, rotating the chain
// through the head cell, taking no command until its last entry. Other
// commands are taken one per cycle while the result side does not stall.
// Reset (sync, active low) empties the list. Depends on pal_pkg and pal_cell.
module positional_array_list (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [pal_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [pal_pkg::VALUE_W-1:0]  i_value,
    input  logic [pal_pkg::POS_W-1:0]           i_position,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [pal_pkg::STATUS_W-1:0]        o_status,
    output logic signed [pal_pkg::VALUE_W-1:0]  o_item_value,
    output logic [pal_pkg::POS_W-1:0]           o_item_index,
    output logic [pal_pkg::COUNT_W-1:0]         o_count_after,
    output logic                                o_last_flag
);

    localparam int CW = pal_pkg::COUNT_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SHOW = 2'b10
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [pal_pkg::POS_W-1:0] r_show_idx, n_show_idx;

    logic                                r_out_valid, n_out_valid;
    logic [pal_pkg::STATUS_W-1:0]        r_status, n_status;
    logic signed [pal_pkg::VALUE_W-1:0]  r_item_value, n_item_value;
    logic [pal_pkg::POS_W-1:0]           r_item_index, n_item_index;
    logic [CW-1:0]                       r_count_after, n_count_after;
    logic                                r_last, n_last;

    logic signed [pal_pkg::VALUE_W-1:0]  w_cell [pal_pkg::CAPACITY];
    pal_pkg::t_cell_op                   w_op   [pal_pkg::CAPACITY];

    logic                        w_slot, w_accept, w_emit, w_show_last;
    logic                        w_ins, w_rem, w_start_show;
    logic [CW-1:0]               w_pos;
    logic [pal_pkg::STATUS_W-1:0] w_cmd_status;
    logic                        w_full, w_empty;

    // handshake
    assign w_slot   = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && w_slot;
    assign w_accept = i_valid && o_ready;
    assign w_emit   = (r_state == S_SHOW) && w_slot;

    assign w_full      = (r_count == CW'(pal_pkg::CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_show_last = ((CW'(r_show_idx) + CW'(1)) == r_count);

    // command decode and status
    always_comb begin
        w_ins        = 1'b0;
        w_rem        = 1'b0;
        w_start_show = 1'b0;
        w_pos        = '0;
        w_cmd_status = pal_pkg::STATUS_OK;
        n_count      = r_count;
        case (i_mode)
            pal_pkg::MODE_INS_TAIL, pal_pkg::MODE_INS_HEAD,
            pal_pkg::MODE_INS_POS: begin
                if (i_mode == pal_pkg::MODE_INS_TAIL)
                    w_pos = r_count;
                else if (i_mode == pal_pkg::MODE_INS_POS)
                    w_pos = CW'(i_position);
                if (w_full)
                    w_cmd_status = pal_pkg::STATUS_FULL;
                else if (w_pos > r_count)
                    w_cmd_status = pal_pkg::STATUS_BADPOS;
                else begin
                    w_ins   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            pal_pkg::MODE_REM_HEAD, pal_pkg::MODE_REM_POS: begin
                if (i_mode == pal_pkg::MODE_REM_POS)
                    w_pos = CW'(i_position);
                if (w_empty)
                    w_cmd_status = pal_pkg::STATUS_EMPTY;
                else if (w_pos >= r_count)
                    w_cmd_status = pal_pkg::STATUS_BADPOS;
                else begin
                    w_rem   = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            pal_pkg::MODE_REM_TAIL: begin
                // tail entry is simply dropped by the count
                if (w_empty)
                    w_cmd_status = pal_pkg::STATUS_EMPTY;
                else
                    n_count = r_count - CW'(1);
            end
            pal_pkg::MODE_SHOW: begin
                if (w_empty)
                    w_cmd_status = pal_pkg::STATUS_EMPTY;
                else
                    w_start_show = 1'b1;
            end
            default: w_cmd_status = pal_pkg::STATUS_BADPOS;
        endcase
        if (!w_accept)
            n_count = r_count;
    end

    // per-cell operation: shift up on insert, down on remove, rotate on show
    always_comb begin
        for (int i = 0; i < pal_pkg::CAPACITY; i++) begin
            w_op[i] = pal_pkg::CELL_HOLD;
            if (w_accept && w_ins) begin
                if (CW'(i) == w_pos)
                    w_op[i] = pal_pkg::CELL_LOAD;
                else if (CW'(i) > w_pos && CW'(i) <= r_count)
                    w_op[i] = pal_pkg::CELL_FROM_PREV;
            end else if (w_accept && w_rem) begin
                if (CW'(i) >= w_pos && CW'(i + 1) < r_count)
                    w_op[i] = pal_pkg::CELL_FROM_NEXT;
            end else if (w_emit) begin
                if (CW'(i + 1) < r_count)
                    w_op[i] = pal_pkg::CELL_FROM_NEXT;
                else if (CW'(i + 1) == r_count)
                    w_op[i] = pal_pkg::CELL_FROM_HEAD;
            end
        end
    end

    // cell chain
    for (genvar g = 0; g < pal_pkg::CAPACITY; g++) begin : g_cell
        logic signed [pal_pkg::VALUE_W-1:0] w_prev, w_next;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_lo
            assign w_prev = w_cell[g-1];
        end
        if (g == pal_pkg::CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_hi
            assign w_next = w_cell[g+1];
        end
        pal_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op[g]),
            .i_load  (i_value),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_head  (w_cell[0]),
            .o_value (w_cell[g])
        );
    end

    // sequencer and output register next values
    always_comb begin
        n_state       = r_state;
        n_show_idx    = r_show_idx;
        n_out_valid   = r_out_valid;
        n_status      = r_status;
        n_item_value  = r_item_value;
        n_item_index  = r_item_index;
        n_count_after = r_count_after;
        n_last        = r_last;
        if (w_slot) begin
            n_out_valid = 1'b0;
            if (w_emit) begin
                n_out_valid   = 1'b1;
                n_status      = pal_pkg::STATUS_OK;
                n_item_value  = w_cell[0];
                n_item_index  = r_show_idx;
                n_count_after = r_count;
                n_last        = w_show_last;
                n_show_idx    = r_show_idx + pal_pkg::POS_W'(1);
                if (w_show_last)
                    n_state = S_IDLE;
            end else if (w_accept) begin
                if (w_start_show) begin
                    n_state    = S_SHOW;
                    n_show_idx = '0;
                end else begin
                    n_out_valid   = 1'b1;
                    n_status      = w_cmd_status;
                    n_item_value  = '0;
                    n_item_index  = '0;
                    n_count_after = n_count;
                    n_last        = 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_show_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_show_idx  <= n_show_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_status      <= n_status;
        r_item_value  <= n_item_value;
        r_item_index  <= n_item_index;
        r_count_after <= n_count_after;
        r_last        <= n_last;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_item_value  = r_item_value;
    assign o_item_index  = r_item_index;
    assign o_count_after = r_count_after;
    assign o_last_flag   = r_last;

endmodule

### rtl/core/pal_checker.sv
// pal_checker: port-level assertions for positional_array_list, bound to
// the top level. Uses pal_pkg.
module pal_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_ready,
    input  logic [pal_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [pal_pkg::VALUE_W-1:0]  i_value,
    input  logic [pal_pkg::POS_W-1:0]           i_position,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic [pal_pkg::STATUS_W-1:0]        o_status,
    input  logic signed [pal_pkg::VALUE_W-1:0]  o_item_value,
    input  logic [pal_pkg::POS_W-1:0]           o_item_index,
    input  logic [pal_pkg::COUNT_W-1:0]         o_count_after,
    input  logic                                o_last_flag
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_item_value) && $stable(o_count_after))
        else $error("result changed while stalled");

    // reset clears the output
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // only show entries can be non-final, and they are ok
    a_mid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_flag |-> o_status == pal_pkg::STATUS_OK)
        else $error("non-final result with error status");

    // error results are final and carry no entry
    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != pal_pkg::STATUS_OK |->
            o_last_flag && o_item_value == 0 && o_item_index == 0)
        else $error("error result malformed");

    // count never exceeds capacity
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_count_after <= pal_pkg::COUNT_W'(pal_pkg::CAPACITY))
        else $error("count beyond capacity");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);

### tb/positional_array_list_tb.sv
// positional_array_list_tb: self-checking bench for the positional array list.
// Holds a mirror of the list that predicts every result and checks the output
// stream against it. Depends on pal_pkg and positional_array_list.
`timescale 1ns / 100ps

module positional_array_list_tb;

    localparam logic [pal_pkg::MODE_W-1:0] MODE_UNDEF = 3'd7;
    localparam int LONG_HOLD     = 60;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ITEMS  = 150;
    localparam int MAX_PRINTED   = 40;

    typedef struct packed {
        logic [pal_pkg::STATUS_W-1:0]        status;
        logic signed [pal_pkg::VALUE_W-1:0]  value;
        logic [pal_pkg::POS_W-1:0]           index;
        logic [pal_pkg::COUNT_W-1:0]         count;
        logic                                last;
    } t_list_result;

    typedef enum {RX_ALWAYS, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_style;

    // Mirror of the list: predicts results per command, checks them in order
    class t_list_mirror;
        logic signed [pal_pkg::VALUE_W-1:0]  cells [pal_pkg::CAPACITY];
        logic [pal_pkg::COUNT_W-1:0]         held;
        t_list_result                        pending [$];
        int                                  errors;

        function new();
            held   = '0;
            errors = 0;
        endfunction

        // insert with shift-up; full check comes before the position check
        function logic [pal_pkg::STATUS_W-1:0] place(
                int unsigned at, logic signed [pal_pkg::VALUE_W-1:0] value);
            if (held >= pal_pkg::CAPACITY) return pal_pkg::STATUS_FULL;
            if (at > held) return pal_pkg::STATUS_BADPOS;
            for (int i = int'(held); i > int'(at); i--) cells[i] = cells[i-1];
            cells[at] = value;
            held++;
            return pal_pkg::STATUS_OK;
        endfunction

        // remove with gap closing; empty check comes before the position check
        function logic [pal_pkg::STATUS_W-1:0] take(int unsigned at);
            if (held == 0) return pal_pkg::STATUS_EMPTY;
            if (at >= held) return pal_pkg::STATUS_BADPOS;
            for (int unsigned i = at; i + 1 < held; i++) cells[i] = cells[i+1];
            held--;
            return pal_pkg::STATUS_OK;
        endfunction

        function void expect_result(logic [pal_pkg::STATUS_W-1:0] status,
                                    logic signed [pal_pkg::VALUE_W-1:0] value,
                                    logic [pal_pkg::POS_W-1:0] index, logic last);
            t_list_result r;
            r.status = status;
            r.value  = value;
            r.index  = index;
            r.count  = held;
            r.last   = last;
            pending.push_back(r);
        endfunction

        // called on every accepted command transfer
        function void note_command(logic [pal_pkg::MODE_W-1:0] mode,
                                   logic signed [pal_pkg::VALUE_W-1:0] value,
                                   logic [pal_pkg::POS_W-1:0] position);
            logic [pal_pkg::STATUS_W-1:0] st;
            case (mode)
                pal_pkg::MODE_INS_TAIL: st = place(32'(held), value);
                pal_pkg::MODE_INS_HEAD: st = place(0, value);
                pal_pkg::MODE_INS_POS:  st = place(32'(position), value);
                pal_pkg::MODE_REM_HEAD: st = take(0);
                // held-1 wraps when empty, but take() reports empty first
                pal_pkg::MODE_REM_TAIL: st = take(32'(held) - 32'd1);
                pal_pkg::MODE_REM_POS:  st = take(32'(position));
                pal_pkg::MODE_SHOW: begin
                    if (held == 0) begin
                        expect_result(pal_pkg::STATUS_EMPTY, '0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < int'(held); i++)
                            expect_result(pal_pkg::STATUS_OK, cells[i],
                                          pal_pkg::POS_W'(i), i == int'(held) - 1);
                    end
                    return;
                end
                default: st = pal_pkg::STATUS_BADPOS;
            endcase
            expect_result(st, '0, '0, 1'b1);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("%0t MISMATCH %s", $realtime, msg);
        endtask

        // called on every accepted result transfer
        task check_result(logic [pal_pkg::STATUS_W-1:0] status,
                          logic signed [pal_pkg::VALUE_W-1:0] value,
                          logic [pal_pkg::POS_W-1:0] index,
                          logic [pal_pkg::COUNT_W-1:0] count, logic last);
            t_list_result want;
            string        diffs;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result st=%0d val=%0d idx=%0d cnt=%0d last=%0b",
                                 status, value, index, count, last));
                return;
            end
            want  = pending.pop_front();
            diffs = "";
            if (status !== want.status) diffs = {diffs, " status"};
            if (value  !== want.value)  diffs = {diffs, " item_value"};
            if (index  !== want.index)  diffs = {diffs, " item_index"};
            if (count  !== want.count)  diffs = {diffs, " count_after"};
            if (last   !== want.last)   diffs = {diffs, " last_flag"};
            if (diffs != "")
                report($sformatf({"[%s ] got st=%0d val=%0d idx=%0d cnt=%0d last=%0b,",
                                  " want st=%0d val=%0d idx=%0d cnt=%0d last=%0b"},
                                 diffs, status, value, index, count, last,
                                 want.status, want.value, want.index, want.count,
                                 want.last));
        endtask
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_ready;
    logic [pal_pkg::MODE_W-1:0]          i_mode;
    logic signed [pal_pkg::VALUE_W-1:0]  i_value;
    logic [pal_pkg::POS_W-1:0]           i_position;
    logic                                o_valid;
    logic                                i_ready;
    logic [pal_pkg::STATUS_W-1:0]        o_status;
    logic signed [pal_pkg::VALUE_W-1:0]  o_item_value;
    logic [pal_pkg::POS_W-1:0]           o_item_index;
    logic [pal_pkg::COUNT_W-1:0]         o_count_after;
    logic                                o_last_flag;

    t_list_mirror mirror;
    int           hold_asked = 0;
    int           hold_given = 0;
    int           random_sent = 0;

    positional_array_list u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_item_value  (o_item_value),
        .o_item_index  (o_item_index),
        .o_count_after (o_count_after),
        .o_last_flag   (o_last_flag)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) mirror.note_command(i_mode, i_value, i_position);
            if (o_valid && i_ready)
                mirror.check_result(o_status, o_item_value, o_item_index, o_count_after,
                                    o_last_flag);
        end
    end

    // Result side: random stall styles in phases of random length; a long hold on request
    initial begin : receiver
        t_rx_style style;
        int        phase_left;
        int        tick;
        style      = RX_ALWAYS;
        phase_left = 0;
        tick       = 0;
        i_ready    = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_asked != hold_given) begin
                hold_given++;
                i_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                if (phase_left == 0) begin
                    style      = t_rx_style'($urandom_range(3));
                    phase_left = $urandom_range(16, 80);
                end
                phase_left--;
                tick++;
                case (style)
                    RX_ALWAYS: i_ready = 1'b1;
                    RX_LIGHT:  i_ready = ($urandom_range(9) >= 3);
                    RX_HEAVY:  i_ready = ($urandom_range(9) >= 7);
                    default:   i_ready = (tick % 5) < 3;
                endcase
                @(negedge i_clk);
            end
        end
    end

    // Present one command at a falling edge and hold it until the transfer
    task send_item(input logic [pal_pkg::MODE_W-1:0] mode,
                   input logic signed [pal_pkg::VALUE_W-1:0] value,
                   input logic [pal_pkg::POS_W-1:0] pos);
        i_valid    = 1'b1;
        i_mode     = mode;
        i_value    = value;
        i_position = pos;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Directed commands, with an occasional short gap after each
    task offer(input logic [pal_pkg::MODE_W-1:0] mode,
               input logic signed [pal_pkg::VALUE_W-1:0] value,
               input logic [pal_pkg::POS_W-1:0] pos);
        send_item(mode, value, pos);
        if ($urandom_range(1) == 1) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    function logic signed [pal_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0;
            3:       return -32'sd1;
            default: return $signed($urandom);
        endcase
    endfunction

    // Random command; fill_pct steers between inserts and removes.
    // Positions mostly land in the legal range for the current count.
    task send_random(input int fill_pct);
        logic [pal_pkg::MODE_W-1:0] mode;
        logic [pal_pkg::POS_W-1:0]  pos;
        int                         roll;
        int                         n;
        n    = int'(mirror.held);
        roll = $urandom_range(99);
        pos  = pal_pkg::POS_W'($urandom_range(7));
        if (roll < 3) begin
            mode = MODE_UNDEF;
        end else if (roll < 10) begin
            mode = pal_pkg::MODE_SHOW;
        end else if (roll < 10 + fill_pct * 90 / 100) begin
            case ($urandom_range(2))
                0:       mode = pal_pkg::MODE_INS_TAIL;
                1:       mode = pal_pkg::MODE_INS_HEAD;
                default: mode = pal_pkg::MODE_INS_POS;
            endcase
            if ($urandom_range(4) != 0)
                pos = pal_pkg::POS_W'($urandom_range((n > 7) ? 7 : n));
        end else begin
            case ($urandom_range(2))
                0:       mode = pal_pkg::MODE_REM_HEAD;
                1:       mode = pal_pkg::MODE_REM_TAIL;
                default: mode = pal_pkg::MODE_REM_POS;
            endcase
            if (n > 0 && $urandom_range(4) != 0)
                pos = pal_pkg::POS_W'($urandom_range(n - 1));
        end
        send_item(mode, pick_value(), pos);
        random_sent++;
    endtask

    // Command side: reset, directed cases, random bursts, then drain
    initial begin : stimulus
        int  burst;
        int  fill_pct;
        bit  hold_done;
        bit  pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        mirror     = new();
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_mode     = pal_pkg::MODE_INS_TAIL;
        i_value    = '0;
        i_position = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty list: show, every remove, undefined mode, insert past the end
        offer(pal_pkg::MODE_SHOW,     '0, 3'd0);
        offer(pal_pkg::MODE_REM_HEAD, '0, 3'd0);
        offer(pal_pkg::MODE_REM_TAIL, '0, 3'd0);
        offer(pal_pkg::MODE_REM_POS,  '0, 3'd7);
        offer(MODE_UNDEF,             32'sh1234_5678, 3'd5);
        offer(pal_pkg::MODE_INS_POS,  32'sd5, 3'd1);
        // fill with the value extremes, insert at count appends
        offer(pal_pkg::MODE_INS_TAIL, 32'sh7fff_ffff, 3'd0);
        offer(pal_pkg::MODE_INS_HEAD, 32'sh8000_0000, 3'd7);
        offer(pal_pkg::MODE_INS_POS,  32'sh0, 3'd2);
        offer(pal_pkg::MODE_INS_POS,  -32'sd1, 3'd1);
        repeat (4)
            offer(pal_pkg::MODE_INS_TAIL, $signed($urandom),
                  pal_pkg::POS_W'($urandom_range(7)));
        // full list: every insert is refused as full
        offer(pal_pkg::MODE_INS_TAIL, 32'sd11, 3'd0);
        offer(pal_pkg::MODE_INS_HEAD, 32'sd12, 3'd0);
        offer(pal_pkg::MODE_INS_POS,  32'sd13, 3'd7);
        offer(pal_pkg::MODE_SHOW,     '0, 3'd0);
        // remove the last slot, then the same slot is out of range
        offer(pal_pkg::MODE_REM_POS,  '0, 3'd7);
        offer(pal_pkg::MODE_REM_POS,  '0, 3'd7);
        offer(pal_pkg::MODE_REM_HEAD, '0, 3'd0);
        offer(pal_pkg::MODE_REM_TAIL, '0, 3'd0);
        offer(MODE_UNDEF,             '0, 3'd0);
        offer(pal_pkg::MODE_SHOW,     '0, 3'd0);

        // random phases that alternate filling, draining and balanced traffic
        while (random_sent < RANDOM_ITEMS) begin
            case ((random_sent / 20) % 3)
                0:       fill_pct = 80;
                1:       fill_pct = 20;
                default: fill_pct = 50;
            endcase
            if (!hold_done && random_sent >= 60) begin
                // result side holds off while commands keep coming
                hold_done = 1'b1;
                hold_asked++;
                repeat (20) send_random(90);
            end else if (!pause_done && random_sent >= 120) begin
                // command side goes quiet until every result is back
                pause_done = 1'b1;
                i_valid    = 1'b0;
                while (mirror.pending.size() != 0) @(negedge i_clk);
            end else begin
                burst = ($urandom_range(7) == 0) ? $urandom_range(15, 30)
                                                 : $urandom_range(1, 8);
                repeat (burst) send_random(fill_pct);
                i_valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end

        i_valid = 1'b0;
        while (mirror.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mirror.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pal_pkg.sv
rtl/core/pal_cell.sv
rtl/core/positional_array_list.sv
rtl/core/pal_checker.sv
tb/positional_array_list_tb.sv
